@@ design/pifr_pkg.sv @@
// Package for the pulse-interval frame receiver.
// Holds buffer sizing, codes, state type and the CRC-16 byte update.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pifr_pkg;

    localparam int BUF_BYTES = 32;
    localparam int IDX_W     = $clog2(BUF_BYTES);
    localparam int BP_W      = 13;
    localparam int TIME_W    = 16;

    localparam logic [BP_W-1:0] BP_RESET  = 13'd800;
    localparam logic [15:0]     CRC_INIT  = 16'hFFFF;
    localparam logic [15:0]     CRC_POLY  = 16'hA001;
    localparam logic [7:0]      MASK_INIT = 8'h80;
    localparam logic [7:0]      ERR_MARK  = 8'hFF;

    localparam logic CMD_EDGE    = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RD,
        ST_LD,
        ST_E0,
        ST_E1,
        ST_E2,
        ST_E3
    } t_state;

    // Modbus CRC-16, reflected, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    localparam logic [15:0] CRC_MARK = crc_byte(CRC_INIT, ERR_MARK);

endpackage

`default_nettype wire

@@ design/pifr_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pifr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/pulse_interval_frame_receiver.sv @@
// Pulse-interval frame receiver: bit decode, frame buffer, CRC-16 check.
// Uses pifr_pkg and pifr_ram.
//
// Input channel (s_axis): tdata = capture_time, tuser = cmd (0 edge,
// 1 end-of-frame timeout). Output channel (m_axis): tdata = one byte,
// tlast = final byte, tuser = byte belongs to the CRC-error report.
// Config: i_cfg_we writes i_cfg_wdata into the bit period (ticks).
//
// An edge word yields nothing; o_s_axis_tready stays high. A timeout
// word folds the open byte into the CRC in its accept cycle, then the
// check state follows. A good frame streams the buffered bytes through
// a buffer RAM read, then an output load per byte; the error report
// streams four bytes at one per cycle while the output is not stalled.
// The next input word is taken once the final output byte is loaded
// into the output register, so it may overlap the delivery of that byte.
// Output is registered; a stalled receiver holds the word and the
// sequencer waits. Reset (synchronous, active low) empties the buffer
// state, the error counter and the output register and sets the bit
// period to 800 ticks; the RAM contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module pulse_interval_frame_receiver (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [pifr_pkg::BP_W-1:0]   i_cfg_wdata,
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire logic [pifr_pkg::TIME_W-1:0] i_s_axis_tdata,  // [15:0] capture_time
    input  wire logic                        i_s_axis_tuser,  // [0] cmd
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    output logic [7:0]                       o_m_axis_tdata,  // [7:0] data_byte
    output logic                             o_m_axis_tlast,
    output logic                             o_m_axis_tuser   // [0] crc_failed
);

    localparam int IW = pifr_pkg::IDX_W;

    pifr_pkg::t_state r_state, n_state;

    logic [pifr_pkg::BP_W-1:0]   r_bp;
    logic [IW-1:0]               r_idx, n_idx;
    logic [7:0]                  r_mask, n_mask;
    logic [7:0]                  r_cur, n_cur;
    logic [15:0]                 r_crc, n_crc;
    logic [7:0]                  r_err, n_err;
    logic [pifr_pkg::TIME_W-1:0] r_last_time, n_last_time;
    logic                        r_last_valid, n_last_valid;
    logic [IW-1:0]               r_emit_last, n_emit_last;
    logic [7:0]                  r_tail, n_tail;
    logic [IW-1:0]               r_rd_idx, n_rd_idx;

    logic       r_o_valid, n_o_valid;
    logic [7:0] r_o_data, n_o_data;
    logic       r_o_last, n_o_last;
    logic       r_o_user, n_o_user;

    logic        s_acc;
    logic        slot_free;
    logic        full;
    logic [15:0] crc_step;
    logic [15:0] rep_crc;
    logic [7:0]  mask_eff;
    logic [IW-1:0] idx_next;
    logic [pifr_pkg::TIME_W-1:0] t_cap;
    logic [pifr_pkg::TIME_W-1:0] delta;
    logic [16:0] thr4, thr8;
    logic        rd_is_tail;

    logic          mem_we, mem_re;
    logic [7:0]    mem_rdata;

    assign o_s_axis_tready = (r_state == pifr_pkg::ST_IDLE);
    assign s_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign slot_free = !r_o_valid || i_m_axis_tready;

    assign full     = (r_mask == 8'h00);
    assign crc_step = pifr_pkg::crc_byte(r_crc, r_cur);
    assign rep_crc  = pifr_pkg::crc_byte(pifr_pkg::CRC_MARK, r_err);
    assign mask_eff = full ? pifr_pkg::MASK_INIT : r_mask;
    assign idx_next = (r_idx == IW'(pifr_pkg::BUF_BYTES - 1)) ? '0 : r_idx + 1'b1;
    assign t_cap    = (i_s_axis_tdata == '0) ? 16'd1 : i_s_axis_tdata;
    assign delta    = t_cap - r_last_time;
    assign thr4     = {2'b00, r_bp, 2'b00};
    assign thr8     = {1'b0, r_bp, 3'b000};
    assign rd_is_tail = (r_rd_idx == r_emit_last);

    assign mem_we = s_acc && (i_s_axis_tuser == pifr_pkg::CMD_EDGE) && r_last_valid
                    && ({1'b0, delta} < thr8) && full;
    assign mem_re = (r_state == pifr_pkg::ST_RD);

    pifr_ram #(
        .WIDTH (8),
        .DEPTH (pifr_pkg::BUF_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_idx),
        .i_wdata (r_cur),
        .i_re    (mem_re),
        .i_raddr (r_rd_idx),
        .o_rdata (mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pifr_pkg::ST_IDLE: begin
                if (s_acc && i_s_axis_tuser == pifr_pkg::CMD_TIMEOUT) begin
                    n_state = pifr_pkg::ST_CHECK;
                end
            end
            pifr_pkg::ST_CHECK: begin
                n_state = (r_crc != 16'h0000) ? pifr_pkg::ST_E0 : pifr_pkg::ST_RD;
            end
            pifr_pkg::ST_RD: n_state = pifr_pkg::ST_LD;
            pifr_pkg::ST_LD: begin
                if (slot_free) begin
                    n_state = rd_is_tail ? pifr_pkg::ST_IDLE : pifr_pkg::ST_RD;
                end
            end
            pifr_pkg::ST_E0: if (slot_free) n_state = pifr_pkg::ST_E1;
            pifr_pkg::ST_E1: if (slot_free) n_state = pifr_pkg::ST_E2;
            pifr_pkg::ST_E2: if (slot_free) n_state = pifr_pkg::ST_E3;
            pifr_pkg::ST_E3: if (slot_free) n_state = pifr_pkg::ST_IDLE;
            default: n_state = pifr_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_idx        = r_idx;
        n_mask       = r_mask;
        n_cur        = r_cur;
        n_crc        = r_crc;
        n_err        = r_err;
        n_last_time  = r_last_time;
        n_last_valid = r_last_valid;
        n_emit_last  = r_emit_last;
        n_tail       = r_tail;
        n_rd_idx     = r_rd_idx;
        n_o_valid    = r_o_valid && !i_m_axis_tready;
        n_o_data     = r_o_data;
        n_o_last     = r_o_last;
        n_o_user     = r_o_user;

        case (r_state)
            pifr_pkg::ST_IDLE: begin
                if (s_acc && i_s_axis_tuser == pifr_pkg::CMD_EDGE) begin
                    n_last_time  = t_cap;
                    n_last_valid = 1'b1;
                    if (r_last_valid && ({1'b0, delta} < thr8)) begin
                        if (full) begin
                            n_crc = crc_step;
                            n_idx = idx_next;
                        end
                        n_cur  = (full ? 8'h00 : r_cur)
                                 | (({1'b0, delta} < thr4) ? 8'h00 : mask_eff);
                        n_mask = mask_eff >> 1;
                    end
                end else if (s_acc) begin
                    n_last_valid = 1'b0;
                    n_crc        = crc_step;
                    n_emit_last  = r_idx;
                    n_tail       = r_cur;
                    n_idx        = '0;
                    n_cur        = 8'h00;
                    n_mask       = pifr_pkg::MASK_INIT;
                end
            end
            pifr_pkg::ST_CHECK: begin
                if (r_crc != 16'h0000) begin
                    n_err = r_err + 8'd1;
                end
                n_crc    = pifr_pkg::CRC_INIT;
                n_rd_idx = '0;
            end
            pifr_pkg::ST_LD: begin
                if (slot_free) begin
                    n_o_valid = 1'b1;
                    n_o_data  = rd_is_tail ? r_tail : mem_rdata;
                    n_o_last  = rd_is_tail;
                    n_o_user  = 1'b0;
                    n_rd_idx  = r_rd_idx + 1'b1;
                end
            end
            pifr_pkg::ST_E0, pifr_pkg::ST_E1, pifr_pkg::ST_E2, pifr_pkg::ST_E3: begin
                if (slot_free) begin
                    n_o_valid = 1'b1;
                    n_o_user  = 1'b1;
                    n_o_last  = (r_state == pifr_pkg::ST_E3);
                    case (r_state)
                        pifr_pkg::ST_E0: n_o_data = pifr_pkg::ERR_MARK;
                        pifr_pkg::ST_E1: n_o_data = r_err;
                        pifr_pkg::ST_E2: n_o_data = rep_crc[7:0];
                        default:         n_o_data = rep_crc[15:8];
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pifr_pkg::ST_IDLE;
            r_bp         <= pifr_pkg::BP_RESET;
            r_idx        <= '0;
            r_mask       <= pifr_pkg::MASK_INIT;
            r_cur        <= 8'h00;
            r_crc        <= pifr_pkg::CRC_INIT;
            r_err        <= 8'h00;
            r_last_time  <= '0;
            r_last_valid <= 1'b0;
            r_emit_last  <= '0;
            r_rd_idx     <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_we) begin
                r_bp <= i_cfg_wdata;
            end
            r_idx        <= n_idx;
            r_mask       <= n_mask;
            r_cur        <= n_cur;
            r_crc        <= n_crc;
            r_err        <= n_err;
            r_last_time  <= n_last_time;
            r_last_valid <= n_last_valid;
            r_emit_last  <= n_emit_last;
            r_rd_idx     <= n_rd_idx;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail   <= n_tail;
        r_o_data <= n_o_data;
        r_o_last <= n_o_last;
        r_o_user <= n_o_user;
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tuser  = r_o_user;

endmodule

`default_nettype wire

@@ design/pifr_checker.sv @@
// Port-level checks for the pulse-interval frame receiver, bound to the top.
// Depends on pulse_interval_frame_receiver.
`timescale 1ns / 1ps
`default_nettype none

module pifr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_s_axis_tvalid,
    input wire logic       o_s_axis_tready,
    input wire logic       i_s_axis_tuser,
    input wire logic       o_m_axis_tvalid,
    input wire logic       i_m_axis_tready,
    input wire logic [7:0] o_m_axis_tdata,
    input wire logic       o_m_axis_tlast,
    input wire logic       o_m_axis_tuser
);

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
            && $stable(o_m_axis_tuser))
        else $error("output word changed under stall");

    // a timeout word starts the check, so input is closed next cycle
    a_timeout_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser |=> !o_s_axis_tready)
        else $error("input open right after a timeout word");

    // mid-frame, no new input is taken
    a_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready)
        else $error("input open while a frame is streaming");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid straight after reset");

endmodule

bind pulse_interval_frame_receiver pifr_checker u_pifr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
